// File: design/baro_vertical_speed_estimator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric vertical speed estimator
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BARO_VERTICAL_SPEED_ESTIMATOR_ASSERT_SVH
`define BARO_VERTICAL_SPEED_ESTIMATOR_ASSERT_SVH

// Same-cycle implication.
`define BVSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvse same-cycle check failed");

// Next-cycle implication.
`define BVSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvse next-cycle check failed");

`endif

// File: design/bvse_pkg.sv
// ----------------------------------------------------------------------------
// bvse_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bvse_pkg;

    localparam int ANG_W      = 16;
    localparam int ALT_W      = 24;
    localparam int DT_W       = 20;
    localparam int CLIMB_W    = 21;
    localparam int LIMIT_W    = 20;
    localparam int GAIN_W     = 17;
    localparam int CFG_DATA_W = 20;
    localparam int GAIN_SHIFT = 16;

    // numerator of the divide: |altitude difference| * 1e6 fits in 44 bits
    localparam int NUM_W      = 44;
    localparam int DIV_CNT_W  = 6;

    localparam logic [DT_W-1:0]    US_PER_S    = 20'd1000000;
    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd5000;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd16384;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_SPEED_LIMIT = 1'b0;
    localparam t_cfg_idx REG_FILTER_GAIN = 1'b1;

    typedef struct packed {
        logic accept;
        logic mul_en;
        logic div_step;
        logic raw_en;
        logic delta_en;
        logic fmul_en;
        logic fadd_en;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: design/bvse_ctrl.sv
// ----------------------------------------------------------------------------
// bvse_ctrl
// Sequencer: steps the datapath through multiply, divide, filter and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module bvse_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire bvse_pkg::t_dp_stat i_stat,
    output bvse_pkg::t_dp_cmd      o_cmd
);
    import bvse_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_RAW    = 4'd3;
    localparam logic [3:0] S_DELTA  = 4'd4;
    localparam logic [3:0] S_FMUL   = 4'd5;
    localparam logic [3:0] S_FADD   = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (i_stat.need_div) begin
                    n_cnt   = DIV_CNT_W'(NUM_W - 1);
                    n_state = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_RAW;
                end else begin
                    n_cnt = r_cnt - DIV_CNT_W'(1);
                end
            end
            S_RAW: begin
                o_cmd.raw_en = 1'b1;
                n_state      = S_DELTA;
            end
            S_DELTA: begin
                o_cmd.delta_en = 1'b1;
                n_state        = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.fmul_en = 1'b1;
                n_state       = S_FADD;
            end
            S_FADD: begin
                o_cmd.fadd_en = 1'b1;
                n_state       = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: design/bvse_datapath.sv
// ----------------------------------------------------------------------------
// bvse_datapath
// Held state, config registers, restoring divider and low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

module bvse_datapath #(
    parameter int SPEED_FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire bvse_pkg::t_cfg_idx               i_cfg_addr,
    input  wire logic [bvse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire bvse_pkg::t_dp_cmd                i_cmd,
    output bvse_pkg::t_dp_stat                    o_stat,
    input  wire logic                             i_imu_ok,
    input  wire logic signed [bvse_pkg::ANG_W-1:0] i_roll_in,
    input  wire logic signed [bvse_pkg::ANG_W-1:0] i_pitch_in,
    input  wire logic signed [bvse_pkg::ANG_W-1:0] i_yaw_in,
    input  wire logic                             i_baro_ok,
    input  wire logic signed [bvse_pkg::ALT_W-1:0] i_altitude_in,
    input  wire logic [bvse_pkg::DT_W-1:0]        i_dt_us,
    output logic signed [bvse_pkg::ANG_W-1:0]     o_roll_out,
    output logic signed [bvse_pkg::ANG_W-1:0]     o_pitch_out,
    output logic signed [bvse_pkg::ANG_W-1:0]     o_yaw_out,
    output logic                                  o_attitude_ok,
    output logic signed [bvse_pkg::ALT_W-1:0]     o_altitude_out,
    output logic signed [bvse_pkg::CLIMB_W-1:0]   o_climb_rate,
    output logic                                  o_altitude_ok
);
    import bvse_pkg::*;

    localparam int SF_W    = CLIMB_W + SPEED_FRAC_BITS;
    localparam int DELTA_W = SF_W + 1;
    localparam int PROD_W  = DELTA_W + GAIN_W + 1;
    localparam int INC_W   = PROD_W - GAIN_SHIFT;

    // configuration
    logic [LIMIT_W-1:0] r_limit;
    logic [GAIN_W-1:0]  r_gain;

    // held state
    logic signed [ANG_W-1:0] r_roll, r_pitch, r_yaw;
    logic                    r_att_flag;
    logic signed [ALT_W-1:0] r_alt;
    logic                    r_alt_flag;
    logic signed [SF_W-1:0]  r_sf;

    // per-item working registers
    logic signed [ALT_W-1:0] r_alt_in;
    logic [DT_W-1:0]         r_dt;
    logic                    r_baro_ok;
    logic                    r_need_div;
    logic                    r_neg;
    logic [DT_W-1:0]         r_rem;
    logic [NUM_W-1:0]        r_quo;
    logic signed [SF_W-1:0]    r_raw;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [PROD_W-1:0]  r_prod;

    logic signed [ALT_W:0]   w_diff;
    logic signed [ALT_W:0]   w_diff_neg;
    logic [ALT_W-1:0]        w_mag;
    logic [NUM_W-1:0]        w_num;
    logic [DT_W:0]           w_shift;
    logic                    w_ge;
    logic [DT_W:0]           w_sub;
    logic [LIMIT_W-1:0]      w_q_cl;
    logic [SF_W-1:0]         w_raw_mag;
    logic [GAIN_W-1:0]       w_gain_cl;
    logic signed [GAIN_W:0]  w_gain_s;
    logic signed [INC_W-1:0] w_inc;
    logic signed [INC_W-1:0] w_sf_sum;

    assign w_diff     = $signed({r_alt_in[ALT_W-1], r_alt_in}) - $signed({r_alt[ALT_W-1], r_alt});
    assign w_diff_neg = -w_diff;
    assign w_mag      = w_diff[ALT_W] ? w_diff_neg[ALT_W-1:0] : w_diff[ALT_W-1:0];
    assign w_num      = NUM_W'(w_mag) * NUM_W'(US_PER_S);

    // one restoring divide step per cycle, quotient shifts in from the right
    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dt});
    assign w_sub   = w_shift - {1'b0, r_dt};

    assign w_q_cl    = (r_quo > NUM_W'(r_limit)) ? r_limit : r_quo[LIMIT_W-1:0];
    assign w_raw_mag = {1'b0, w_q_cl, {SPEED_FRAC_BITS{1'b0}}};

    assign w_gain_cl = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
    assign w_gain_s  = $signed({1'b0, w_gain_cl});

    // floor shift of the product, then add back onto the filter state
    assign w_inc    = r_prod[PROD_W-1:GAIN_SHIFT];
    assign w_sf_sum = $signed({{(INC_W-SF_W){r_sf[SF_W-1]}}, r_sf}) + w_inc;

    assign o_stat.need_div = r_need_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_gain     <= GAIN_RESET;
            r_roll     <= '0;
            r_pitch    <= '0;
            r_yaw      <= '0;
            r_att_flag <= 1'b0;
            r_alt      <= '0;
            r_alt_flag <= 1'b0;
            r_sf       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SPEED_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                    REG_FILTER_GAIN: r_gain  <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_imu_ok) begin
                    r_roll  <= i_roll_in;
                    r_pitch <= i_pitch_in;
                    r_yaw   <= i_yaw_in;
                end
                r_att_flag <= i_imu_ok;
            end
            if (i_cmd.fadd_en) begin
                r_sf <= w_sf_sum[SF_W-1:0];
            end
            if (i_cmd.commit) begin
                if (r_baro_ok) begin
                    r_alt <= r_alt_in;
                end
                r_alt_flag <= r_baro_ok;
                if (!r_need_div) begin
                    r_sf <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_alt_in   <= i_altitude_in;
            r_dt       <= i_dt_us;
            r_baro_ok  <= i_baro_ok;
            r_need_div <= i_baro_ok && r_alt_flag && (i_dt_us != '0);
        end
        if (i_cmd.mul_en) begin
            r_neg <= w_diff[ALT_W];
            r_quo <= w_num;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[DT_W-1:0] : w_shift[DT_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
        if (i_cmd.raw_en) begin
            r_raw <= r_neg ? -$signed(w_raw_mag) : $signed(w_raw_mag);
        end
        if (i_cmd.delta_en) begin
            r_delta <= $signed({r_raw[SF_W-1], r_raw}) - $signed({r_sf[SF_W-1], r_sf});
        end
        if (i_cmd.fmul_en) begin
            r_prod <= r_delta * w_gain_s;
        end
        if (i_cmd.out_load) begin
            o_roll_out     <= r_roll;
            o_pitch_out    <= r_pitch;
            o_yaw_out      <= r_yaw;
            o_attitude_ok  <= r_att_flag;
            o_altitude_out <= r_alt;
            o_climb_rate   <= r_sf[SF_W-1:SPEED_FRAC_BITS];
            o_altitude_ok  <= r_alt_flag;
        end
    end

endmodule

`default_nettype wire

// File: design/baro_vertical_speed_estimator.sv
// Order: accept, multiply, then commit when no divide is needed (bad baro,
//   first valid altitude or zero dt), else the 44-step divider and filter run first.
// Flow: one item in flight; a new beat is taken while the previous result still
//   waits in the output register.
// Reset: synchronous active-low; held state, flags and filter cleared, config
//   registers return to speed limit 5000 mm/s and gain 0.25.
// ----------------------------------------------------------------------------
// baro_vertical_speed_estimator
// Holds attitude and altitude, derives climb rate by finite difference over
// dt, clamps it and smooths it with a first-order low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "baro_vertical_speed_estimator_assert.svh"

module baro_vertical_speed_estimator #(
    parameter int SPEED_FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire bvse_pkg::t_cfg_idx                i_cfg_addr,
    input  wire logic [bvse_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_imu_ok,
    input  wire logic signed [bvse_pkg::ANG_W-1:0] i_roll_in,
    input  wire logic signed [bvse_pkg::ANG_W-1:0] i_pitch_in,
    input  wire logic signed [bvse_pkg::ANG_W-1:0] i_yaw_in,
    input  wire logic                              i_baro_ok,
    input  wire logic signed [bvse_pkg::ALT_W-1:0] i_altitude_in,
    input  wire logic [bvse_pkg::DT_W-1:0]         i_dt_us,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [bvse_pkg::ANG_W-1:0]      o_roll_out,
    output logic signed [bvse_pkg::ANG_W-1:0]      o_pitch_out,
    output logic signed [bvse_pkg::ANG_W-1:0]      o_yaw_out,
    output logic                                   o_attitude_ok,
    output logic signed [bvse_pkg::ALT_W-1:0]      o_altitude_out,
    output logic signed [bvse_pkg::CLIMB_W-1:0]    o_climb_rate,
    output logic                                   o_altitude_ok
);
    import bvse_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller walks: accept -> multiply |diff| by 1e6 -> 44 divide
    // steps -> clamp -> subtract filter state -> gain multiply -> add ->
    // commit -> load output. Items that need no divide skip straight from
    // the multiply to the commit, which then zeroes the filter state.
    bvse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Attitude is latched on accept; altitude changes only at commit and the
    // filter state at the add or commit, so the divide sees the previous altitude.
    bvse_datapath #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_imu_ok       (i_imu_ok),
        .i_roll_in      (i_roll_in),
        .i_pitch_in     (i_pitch_in),
        .i_yaw_in       (i_yaw_in),
        .i_baro_ok      (i_baro_ok),
        .i_altitude_in  (i_altitude_in),
        .i_dt_us        (i_dt_us),
        .o_roll_out     (o_roll_out),
        .o_pitch_out    (o_pitch_out),
        .o_yaw_out      (o_yaw_out),
        .o_attitude_ok  (o_attitude_ok),
        .o_altitude_out (o_altitude_out),
        .o_climb_rate   (o_climb_rate),
        .o_altitude_ok  (o_altitude_ok)
    );

    // One item at a time: after an accepted beat the input side must close.
    `BVSE_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // Loading the output register always presents a result next cycle.
    `BVSE_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.out_load, o_out_valid)
    // Commit never overlaps a filter update or a new accept.
    `BVSE_ASSERT_IMPLY(a_commit_alone, i_clk, i_rst_n, w_cmd.commit, !w_cmd.fadd_en && !w_cmd.accept)

endmodule

`default_nettype wire
